/* hdl/priority_schedule_wait_times_macros.svh */
// Assertion macros used by the checker file.
`ifndef PRIORITY_SCHEDULE_WAIT_TIMES_MACROS_SVH
`define PRIORITY_SCHEDULE_WAIT_TIMES_MACROS_SVH

// Same-cycle implication.
`define PSWT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pswt check failed");

// Next-cycle implication.
`define PSWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pswt check failed");

`endif

/* hdl/pswt_pkg.sv */
// Shared constants and types of the priority scheduler.
package pswt_pkg;

   localparam int MAX_JOBS = 32;
   localparam int COUNT_W  = $clog2(MAX_JOBS + 1);
   localparam int IDX_W    = $clog2(MAX_JOBS);
   localparam int BURST_W  = 16;
   localparam int PRIO_W   = 8;
   localparam int TIME_W   = 22;
   localparam int PNUM_W   = 7;
   localparam int SUM_W    = TIME_W + COUNT_W;
   localparam int REM_W    = COUNT_W + 1;
   localparam int DCNT_W   = $clog2(SUM_W);

   typedef struct packed {
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic [IDX_W-1:0]   origin;
   } entry_type;

   typedef struct packed {
      logic load;
      logic sort_begin;
      logic row_begin;
      logic scan_cmp;
      logic swap_a;
      logic swap_b;
      logic sum_begin;
      logic sum_acc;
      logic div_begin;
      logic div_step;
      logic out_begin;
      logic out_load;
      logic batch_end;
   } cmd_type;

   typedef struct packed {
      logic last_accept;
      logic i_done;
      logic j_last;
      logic div_last;
      logic rsp_taken;
      logic out_end;
   } status_type;

endpackage

/* hdl/pswt_ctrl.sv */
// Sequencer for load, sort, sum, divide and result phases.
module pswt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  pswt_pkg::status_type st,
   output pswt_pkg::cmd_type    cmd,
   output logic                 req_stall
);

   typedef enum logic [11:0] {
      ST_LOAD     = 12'b000000000001,
      ST_ROW      = 12'b000000000010,
      ST_SCAN_RD  = 12'b000000000100,
      ST_SCAN_CMP = 12'b000000001000,
      ST_SWAP_A   = 12'b000000010000,
      ST_SWAP_B   = 12'b000000100000,
      ST_SUM_RD   = 12'b000001000000,
      ST_SUM_ACC  = 12'b000010000000,
      ST_DIV      = 12'b000100000000,
      ST_OUT_RD   = 12'b001000000000,
      ST_OUT_LOAD = 12'b010000000000,
      ST_OUT_WAIT = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            cmd.load = 1'b1;
            if (st.last_accept) begin
               cmd.sort_begin = 1'b1;
               state_in       = ST_ROW;
            end
         end
         ST_ROW: begin
            if (st.i_done) begin
               cmd.sum_begin = 1'b1;
               state_in      = ST_SUM_RD;
            end else begin
               cmd.row_begin = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in     = st.j_last ? ST_SWAP_A : ST_SCAN_RD;
         end
         ST_SWAP_A: begin
            cmd.swap_a = 1'b1;
            state_in   = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            cmd.swap_b = 1'b1;
            state_in   = ST_ROW;
         end
         ST_SUM_RD: state_in = ST_SUM_ACC;
         ST_SUM_ACC: begin
            cmd.sum_acc = 1'b1;
            if (st.j_last) begin
               cmd.div_begin = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_SUM_RD;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               cmd.out_begin = 1'b1;
               state_in      = ST_OUT_RD;
            end
         end
         ST_OUT_RD: state_in = ST_OUT_LOAD;
         ST_OUT_LOAD: begin
            cmd.out_load = 1'b1;
            state_in     = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (st.rsp_taken) begin
               if (st.out_end) begin
                  cmd.batch_end = 1'b1;
                  state_in      = ST_LOAD;
               end else begin
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_LOAD);

endmodule

/* hdl/pswt_datapath.sv */
// Job store, sort compare, running sums, dividers and result register.
module pswt_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  pswt_pkg::cmd_type             cmd,
   output pswt_pkg::status_type          st,
   input  logic                          req_valid,
   input  logic [pswt_pkg::BURST_W-1:0]  req_burst_time,
   input  logic [pswt_pkg::PRIO_W-1:0]   req_priority_req,
   input  logic                          req_last_job,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pswt_pkg::PNUM_W-1:0]   rsp_process_number,
   output logic [pswt_pkg::BURST_W-1:0]  rsp_job_burst,
   output logic [pswt_pkg::TIME_W-1:0]   rsp_waiting_time,
   output logic [pswt_pkg::TIME_W-1:0]   rsp_turnaround_time,
   output logic [pswt_pkg::TIME_W-1:0]   rsp_average_wait,
   output logic [pswt_pkg::TIME_W-1:0]   rsp_average_turnaround,
   output logic                          rsp_jobs_dropped,
   output logic                          rsp_end_of_schedule
);

   localparam int CW = pswt_pkg::COUNT_W;
   localparam int IW = pswt_pkg::IDX_W;
   localparam int SW = pswt_pkg::SUM_W;
   localparam int RW = pswt_pkg::REM_W;
   localparam int TW = pswt_pkg::TIME_W;
   localparam int DW = pswt_pkg::DCNT_W;

   function automatic logic [RW+SW-1:0] div_iter(input logic [RW-1:0] rem,
                                                 input logic [SW-1:0] quo,
                                                 input logic [CW-1:0] dvs);
      logic [RW-1:0] sh;
      logic [SW-1:0] q;
      sh = {rem[CW-1:0], quo[SW-1]};
      q  = {quo[SW-2:0], 1'b0};
      if (sh >= {1'b0, dvs}) begin
         sh   = sh - {1'b0, dvs};
         q[0] = 1'b1;
      end
      return {sh, q};
   endfunction

   pswt_pkg::entry_type entry_mem [pswt_pkg::MAX_JOBS];
   pswt_pkg::entry_type rd_ff;
   pswt_pkg::entry_type wr_data;
   logic [IW-1:0]       wr_addr;
   logic                wr_en;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   pswt_pkg::entry_type first_ff, first_in, best_ff, best_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [TW-1:0] elapsed_ff, elapsed_in;
   logic [SW-1:0] wsum_ff, wsum_in, tsum_ff, tsum_in;
   logic [SW-1:0] wq_ff, wq_in, tq_ff, tq_in;
   logic [RW-1:0] wr_rem_ff, wr_rem_in, tr_rem_ff, tr_rem_in;
   logic [DW-1:0] dcnt_ff, dcnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [pswt_pkg::PNUM_W-1:0]  pnum_ff, pnum_in;
   logic [pswt_pkg::BURST_W-1:0] burst_ff, burst_in;
   logic [TW-1:0] wait_ff, wait_in, tat_ff, tat_in;
   logic          drop_ff, drop_in, end_ff, end_in;
   logic          room;
   logic [TW-1:0] next_elapsed;

   assign room         = (cnt_ff < CW'(pswt_pkg::MAX_JOBS));
   assign next_elapsed = elapsed_ff + TW'(rd_ff.burst);

   assign st.last_accept = req_valid && req_last_job;
   assign st.i_done      = (i_ff == cnt_ff);
   assign st.j_last      = ((j_ff + CW'(1)) == cnt_ff);
   assign st.div_last    = (dcnt_ff == DW'(SW - 1));
   assign st.rsp_taken   = rsp_valid_ff && !rsp_stall;
   assign st.out_end     = end_ff;

   // store write port: load, then the two halves of a swap
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff[IW-1:0];
      wr_data = '{burst: req_burst_time, prio: req_priority_req, origin: cnt_ff[IW-1:0]};
      if (cmd.load && req_valid && room) begin
         wr_en = 1'b1;
      end else if (cmd.swap_a) begin
         wr_en   = 1'b1;
         wr_addr = i_ff[IW-1:0];
         wr_data = best_ff;
      end else if (cmd.swap_b) begin
         wr_en   = 1'b1;
         wr_addr = best_idx_ff;
         wr_data = first_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_ff <= entry_mem[j_ff[IW-1:0]];
   end

   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      first_in     = first_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      elapsed_in   = elapsed_ff;
      wsum_in      = wsum_ff;
      tsum_in      = tsum_ff;
      wq_in        = wq_ff;
      tq_in        = tq_ff;
      wr_rem_in    = wr_rem_ff;
      tr_rem_in    = tr_rem_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      pnum_in      = pnum_ff;
      burst_in     = burst_ff;
      wait_in      = wait_ff;
      tat_in       = tat_ff;
      drop_in      = drop_ff;
      end_in       = end_ff;

      if (cmd.load && req_valid) begin
         if (room) cnt_in = cnt_ff + CW'(1);
         else      ovf_in = 1'b1;
      end
      if (cmd.batch_end) begin
         cnt_in = '0;
         ovf_in = 1'b0;
      end
      if (cmd.sort_begin) i_in = '0;
      if (cmd.swap_b)     i_in = i_ff + CW'(1);

      if (cmd.row_begin) j_in = i_ff;
      if (cmd.sum_begin || cmd.out_begin) begin
         j_in       = '0;
         elapsed_in = '0;
      end
      if (cmd.sum_begin) begin
         wsum_in = '0;
         tsum_in = '0;
      end

      if (cmd.scan_cmp) begin
         j_in = j_ff + CW'(1);
         // first entry of the row seeds the minimum search
         if (j_ff == i_ff) begin
            first_in    = rd_ff;
            best_in     = rd_ff;
            best_idx_in = j_ff[IW-1:0];
         end else if (rd_ff.prio < best_ff.prio) begin
            best_in     = rd_ff;
            best_idx_in = j_ff[IW-1:0];
         end
      end

      if (cmd.sum_acc) begin
         j_in       = j_ff + CW'(1);
         elapsed_in = next_elapsed;
         wsum_in    = wsum_ff + SW'(elapsed_ff);
         tsum_in    = tsum_ff + SW'(next_elapsed);
      end

      // sums are taken from the same-cycle update of the final accumulate
      if (cmd.div_begin) begin
         wq_in     = wsum_in;
         tq_in     = tsum_in;
         wr_rem_in = '0;
         tr_rem_in = '0;
         dcnt_in   = '0;
      end
      if (cmd.div_step) begin
         {wr_rem_in, wq_in} = div_iter(wr_rem_ff, wq_ff, cnt_ff);
         {tr_rem_in, tq_in} = div_iter(tr_rem_ff, tq_ff, cnt_ff);
         dcnt_in            = dcnt_ff + DW'(1);
      end

      if (st.rsp_taken) rsp_valid_in = 1'b0;
      if (cmd.out_load) begin
         j_in         = j_ff + CW'(1);
         elapsed_in   = next_elapsed;
         rsp_valid_in = 1'b1;
         pnum_in      = pswt_pkg::PNUM_W'(rd_ff.origin) + pswt_pkg::PNUM_W'(1);
         burst_in     = rd_ff.burst;
         wait_in      = elapsed_ff;
         tat_in       = next_elapsed;
         drop_in      = ovf_ff;
         end_in       = st.j_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      first_ff    <= first_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      elapsed_ff  <= elapsed_in;
      wsum_ff     <= wsum_in;
      tsum_ff     <= tsum_in;
      wq_ff       <= wq_in;
      tq_ff       <= tq_in;
      wr_rem_ff   <= wr_rem_in;
      tr_rem_ff   <= tr_rem_in;
      dcnt_ff     <= dcnt_in;
      pnum_ff     <= pnum_in;
      burst_ff    <= burst_in;
      wait_ff     <= wait_in;
      tat_ff      <= tat_in;
      drop_ff     <= drop_in;
      end_ff      <= end_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_process_number     = pnum_ff;
   assign rsp_job_burst          = burst_ff;
   assign rsp_waiting_time       = wait_ff;
   assign rsp_turnaround_time    = tat_ff;
   assign rsp_average_wait       = wq_ff[TW-1:0];
   assign rsp_average_turnaround = tq_ff[TW-1:0];
   assign rsp_jobs_dropped       = drop_ff;
   assign rsp_end_of_schedule    = end_ff;

endmodule

/* hdl/priority_schedule_wait_times.sv */
// Top level of the non-preemptive priority scheduler.
//
//   channel  dir  handshake           beat contents
//   req      in   req_valid/req_stall burst time, priority, last-job mark
//   rsp      out  rsp_valid/rsp_stall one scheduled job with times and averages
//
// Jobs load one beat per cycle while req_stall is low. After the last job, a
// selection sort over the store runs row by row (single read port), then the
// sum pass, then the two shared-step dividers; each result is then presented
// on rsp and held while rsp_stall is high.
// req_stall stays high from the last job until the final result is taken.
// Reset clears the job count, overflow flag, sequencer and rsp_valid; the store
// needs no clearing.
module priority_schedule_wait_times (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pswt_pkg::BURST_W-1:0]  req_burst_time,
   input  logic [pswt_pkg::PRIO_W-1:0]   req_priority_req,
   input  logic                          req_last_job,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pswt_pkg::PNUM_W-1:0]   rsp_process_number,
   output logic [pswt_pkg::BURST_W-1:0]  rsp_job_burst,
   output logic [pswt_pkg::TIME_W-1:0]   rsp_waiting_time,
   output logic [pswt_pkg::TIME_W-1:0]   rsp_turnaround_time,
   output logic [pswt_pkg::TIME_W-1:0]   rsp_average_wait,
   output logic [pswt_pkg::TIME_W-1:0]   rsp_average_turnaround,
   output logic                          rsp_jobs_dropped,
   output logic                          rsp_end_of_schedule
);

   pswt_pkg::cmd_type    cmd;
   pswt_pkg::status_type st;

   pswt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .st        (st),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   pswt_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .st                     (st),
      .req_valid              (req_valid),
      .req_burst_time         (req_burst_time),
      .req_priority_req       (req_priority_req),
      .req_last_job           (req_last_job),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_process_number     (rsp_process_number),
      .rsp_job_burst          (rsp_job_burst),
      .rsp_waiting_time       (rsp_waiting_time),
      .rsp_turnaround_time    (rsp_turnaround_time),
      .rsp_average_wait       (rsp_average_wait),
      .rsp_average_turnaround (rsp_average_turnaround),
      .rsp_jobs_dropped       (rsp_jobs_dropped),
      .rsp_end_of_schedule    (rsp_end_of_schedule)
   );

endmodule

/* hdl/pswt_checker.sv */
// Port-level checks for the scheduler, bound to the top level.
`include "priority_schedule_wait_times_macros.svh"

module pswt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [pswt_pkg::PNUM_W-1:0]   rsp_process_number,
   input logic [pswt_pkg::BURST_W-1:0]  rsp_job_burst,
   input logic [pswt_pkg::TIME_W-1:0]   rsp_waiting_time,
   input logic [pswt_pkg::TIME_W-1:0]   rsp_turnaround_time
);

   `PSWT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_waiting_time))
   `PSWT_ASSERT_IMPLY(a_no_load_during_rsp, clock, reset, rsp_valid, req_stall)
   `PSWT_ASSERT_IMPLY(a_tat_sum, clock, reset, rsp_valid, rsp_turnaround_time == rsp_waiting_time + pswt_pkg::TIME_W'(rsp_job_burst))
   `PSWT_ASSERT_IMPLY(a_pnum_nonzero, clock, reset, rsp_valid, rsp_process_number != '0)
   `PSWT_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall)

endmodule

bind priority_schedule_wait_times pswt_checker u_pswt_checker (.*);
